// ----- hdl/dsbu_pkg.sv -----
// Shared constants for the debug step and breakpoint unit: command codes,
// step modes, stop reasons and default sizes.
// No dependencies; every other file of the unit but dsbu_csr_if refers to this package.
package dsbu_pkg;

   // Default sizes handed to the top level parameters
   localparam int BP_SLOTS_DEF   = 16;
   localparam int LINE_BITS_DEF  = 20;
   localparam int DEPTH_BITS_DEF = 8;
   localparam int FILE_BITS_DEF  = 8;

   // Fixed field widths
   localparam int ACTION_BITS = 3;
   localparam int FRAME_BITS  = 8;
   localparam int SLOT_BITS   = 4;
   localparam int MODE_BITS   = 2;
   localparam int REASON_BITS = 2;

   // Command codes carried in the action field
   localparam logic [ACTION_BITS-1:0] ACT_INSTR    = 3'd0;
   localparam logic [ACTION_BITS-1:0] ACT_CONTINUE = 3'd1;
   localparam logic [ACTION_BITS-1:0] ACT_STEP_OVR = 3'd2;
   localparam logic [ACTION_BITS-1:0] ACT_STEP_IN  = 3'd3;
   localparam logic [ACTION_BITS-1:0] ACT_STEP_OUT = 3'd4;
   localparam logic [ACTION_BITS-1:0] ACT_PAUSE    = 3'd5;
   localparam logic [ACTION_BITS-1:0] ACT_BP_WRITE = 3'd6;

   // Step modes
   localparam logic [MODE_BITS-1:0] MODE_NONE = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_OVER = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_INTO = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_OUT  = 2'd3;

   // Stop reasons
   localparam logic [REASON_BITS-1:0] REASON_STEP  = 2'd0;
   localparam logic [REASON_BITS-1:0] REASON_PAUSE = 2'd1;
   localparam logic [REASON_BITS-1:0] REASON_BP    = 2'd2;

endpackage

// ----- hdl/dsbu_req_if.sv -----
// Request channel of the debug stop unit: instruction events and host commands.
// Depends on dsbu_pkg for the fixed field widths.
interface dsbu_req_if #(
   parameter int FILE_BITS  = dsbu_pkg::FILE_BITS_DEF,
   parameter int LINE_BITS  = dsbu_pkg::LINE_BITS_DEF,
   parameter int DEPTH_BITS = dsbu_pkg::DEPTH_BITS_DEF
);
   logic                             valid;
   logic                             ready;
   logic [dsbu_pkg::ACTION_BITS-1:0] action;
   logic [FILE_BITS-1:0]             file_id;
   logic [LINE_BITS-1:0]             line;
   logic [DEPTH_BITS-1:0]            call_depth;
   logic [dsbu_pkg::FRAME_BITS-1:0]  frame_num;
   logic                             has_line_info;
   logic [dsbu_pkg::SLOT_BITS-1:0]   slot;
   logic                             slot_enable;

   modport source (
      output valid, action, file_id, line, call_depth, frame_num,
             has_line_info, slot, slot_enable,
      input  ready
   );
   modport sink (
      input  valid, action, file_id, line, call_depth, frame_num,
             has_line_info, slot, slot_enable,
      output ready
   );
endinterface

// ----- hdl/dsbu_rsp_if.sv -----
// Response channel of the debug stop unit: one result per request.
// Depends on dsbu_pkg for the fixed field widths.
interface dsbu_rsp_if #(
   parameter int FILE_BITS = dsbu_pkg::FILE_BITS_DEF,
   parameter int LINE_BITS = dsbu_pkg::LINE_BITS_DEF
);
   logic                             valid;
   logic                             ready;
   logic                             stopped;
   logic [dsbu_pkg::REASON_BITS-1:0] stop_reason;
   logic [dsbu_pkg::FRAME_BITS-1:0]  stop_frame;
   logic [FILE_BITS-1:0]             stop_file;
   logic [LINE_BITS-1:0]             stop_line;
   logic                             paused;
   logic                             rejected;

   modport source (
      output valid, stopped, stop_reason, stop_frame, stop_file, stop_line,
             paused, rejected,
      input  ready
   );
   modport sink (
      input  valid, stopped, stop_reason, stop_frame, stop_file, stop_line,
             paused, rejected,
      output ready
   );
endinterface

// ----- hdl/dsbu_csr_if.sv -----
// Configuration write channel of the debug stop unit (hook enable register).
// No dependencies.
interface dsbu_csr_if;
   logic valid;
   logic ready;
   logic hook_enabled;

   modport source (output valid, hook_enabled, input ready);
   modport sink (input valid, hook_enabled, output ready);
endinterface

// ----- hdl/dsbu_bp_table.sv -----
// Breakpoint table: one register slot per breakpoint with a parallel comparator.
// Depends on dsbu_pkg for its parameter defaults; instantiated by the top level.
module dsbu_bp_table #(
   parameter int BP_SLOTS  = dsbu_pkg::BP_SLOTS_DEF,
   parameter int FILE_BITS = dsbu_pkg::FILE_BITS_DEF,
   parameter int LINE_BITS = dsbu_pkg::LINE_BITS_DEF,
   parameter int SLOT_BITS = dsbu_pkg::SLOT_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [SLOT_BITS-1:0] wr_slot,
   input  logic                 wr_arm,
   input  logic [FILE_BITS-1:0] wr_file,
   input  logic [LINE_BITS-1:0] wr_line,
   input  logic [FILE_BITS-1:0] look_file,
   input  logic [LINE_BITS-1:0] look_line,
   output logic                 hit
);

   logic [BP_SLOTS-1:0]  armed_ff;
   logic [FILE_BITS-1:0] file_ff [BP_SLOTS];
   logic [LINE_BITS-1:0] line_ff [BP_SLOTS];
   logic [BP_SLOTS-1:0]  match;
   logic [BP_SLOTS-1:0]  sel;

   for (genvar k = 0; k < BP_SLOTS; k++) begin : g_slot
      // Write the slot whose number matches; slot numbers past the table match none
      assign sel[k] = wr_en && (32'(wr_slot) == 32'(k));

      always_ff @(posedge clock) begin
         if (reset) begin
            armed_ff[k] <= 1'b0;
         end else if (sel[k]) begin
            armed_ff[k] <= wr_arm;
         end
      end

      always_ff @(posedge clock) begin
         if (sel[k]) begin
            file_ff[k] <= wr_file;
            line_ff[k] <= wr_line;
         end
      end

      // Compare this slot against the looked-up position
      assign match[k] = armed_ff[k] && (file_ff[k] == look_file)
                        && (line_ff[k] == look_line);
   end

   assign hit = |match;

endmodule

// ----- hdl/debug_step_breakpoint_unit.sv -----
// Top level of the debug step and breakpoint unit.
// Depends on dsbu_pkg, the three channel interfaces and dsbu_bp_table.
//
// Takes one transaction per cycle while responses are taken: an instruction
// event or a host command (continue, step over/into/out, pause request,
// breakpoint slot write). Each request passes through an input register, is
// decided combinationally against the step state and all breakpoint slots at
// once, and leaves through an output register, so every request gives exactly
// one response and a new request can be accepted every cycle while responses are
// taken. A response that is not taken stalls the input register, and then the
// request channel. An instruction event is weighed in priority order: pending
// pause, active step rule, then breakpoint match. Instruction events that
// arrive while paused are rejected; those with the hook disabled, no line
// information or a frame index not below the call depth are passed over
// without effect. The hook enable register takes writes in any cycle.
module debug_step_breakpoint_unit #(
   parameter int BP_SLOTS   = dsbu_pkg::BP_SLOTS_DEF,
   parameter int LINE_BITS  = dsbu_pkg::LINE_BITS_DEF,
   parameter int DEPTH_BITS = dsbu_pkg::DEPTH_BITS_DEF,
   parameter int FILE_BITS  = dsbu_pkg::FILE_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   dsbu_req_if.sink  req_ch,
   dsbu_rsp_if.source rsp_ch,
   dsbu_csr_if.sink  csr_ch
);

   localparam int SLOT_BITS = dsbu_pkg::SLOT_BITS;
   localparam int CMP_BITS  = (DEPTH_BITS > dsbu_pkg::FRAME_BITS) ?
                              DEPTH_BITS : dsbu_pkg::FRAME_BITS;

   // Configuration register
   logic hook_ff;

   // Step and pause state
   logic [dsbu_pkg::MODE_BITS-1:0] step_mode_ff, step_mode_in;
   logic [DEPTH_BITS-1:0]          step_depth_ff, step_depth_in;
   logic [LINE_BITS-1:0]           step_line_ff, step_line_in;
   logic [DEPTH_BITS-1:0]          stop_depth_ff, stop_depth_in;
   logic [LINE_BITS-1:0]           stop_line_ff, stop_line_in;
   logic                           paused_ff, paused_in;
   logic                           pending_ff, pending_in;

   // Input register
   logic                             s1_valid_ff;
   logic [dsbu_pkg::ACTION_BITS-1:0] s1_action_ff;
   logic [FILE_BITS-1:0]             s1_file_ff;
   logic [LINE_BITS-1:0]             s1_line_ff;
   logic [DEPTH_BITS-1:0]            s1_depth_ff;
   logic [dsbu_pkg::FRAME_BITS-1:0]  s1_frame_ff;
   logic                             s1_has_line_ff;
   logic [SLOT_BITS-1:0]             s1_slot_ff;
   logic                             s1_slot_en_ff;

   // Output register
   logic                             rsp_valid_ff;
   logic                             rsp_stopped_ff, rsp_stopped_in;
   logic [dsbu_pkg::REASON_BITS-1:0] rsp_reason_ff, rsp_reason_in;
   logic [dsbu_pkg::FRAME_BITS-1:0]  rsp_frame_ff;
   logic [FILE_BITS-1:0]             rsp_file_ff;
   logic [LINE_BITS-1:0]             rsp_line_ff;
   logic                             rsp_paused_ff;
   logic                             rsp_rejected_ff, rsp_rejected_in;

   logic advance;
   logic bp_hit;
   logic bp_wr;
   logic eligible;
   logic step_hit;

   // Configuration port always ready
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hook_ff <= 1'b0;
      end else if (csr_ch.valid) begin
         hook_ff <= csr_ch.hook_enabled;
      end
   end

   // Advance the input register into the output register when it is free
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         s1_action_ff   <= req_ch.action;
         s1_file_ff     <= req_ch.file_id;
         s1_line_ff     <= req_ch.line;
         s1_depth_ff    <= req_ch.call_depth;
         s1_frame_ff    <= req_ch.frame_num;
         s1_has_line_ff <= req_ch.has_line_info;
         s1_slot_ff     <= req_ch.slot;
         s1_slot_en_ff  <= req_ch.slot_enable;
      end
   end

   // Breakpoint slots
   assign bp_wr = advance && (s1_action_ff == dsbu_pkg::ACT_BP_WRITE);

   dsbu_bp_table #(
      .BP_SLOTS  (BP_SLOTS),
      .FILE_BITS (FILE_BITS),
      .LINE_BITS (LINE_BITS),
      .SLOT_BITS (SLOT_BITS)
   ) u_bp_table (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (bp_wr),
      .wr_slot   (s1_slot_ff),
      .wr_arm    (s1_slot_en_ff),
      .wr_file   (s1_file_ff),
      .wr_line   (s1_line_ff),
      .look_file (s1_file_ff),
      .look_line (s1_line_ff),
      .hit       (bp_hit)
   );

   // Instruction qualifies for stop evaluation
   assign eligible = hook_ff && s1_has_line_ff &&
                     (CMP_BITS'(s1_frame_ff) < CMP_BITS'(s1_depth_ff));

   // Apply the active step rule
   always_comb begin
      unique case (step_mode_ff)
         dsbu_pkg::MODE_OVER: step_hit = (s1_depth_ff < step_depth_ff) ||
                                         ((s1_depth_ff == step_depth_ff) &&
                                          (s1_line_ff != step_line_ff));
         dsbu_pkg::MODE_INTO: step_hit = (s1_depth_ff != step_depth_ff) ||
                                         (s1_line_ff != step_line_ff);
         dsbu_pkg::MODE_OUT:  step_hit = (s1_depth_ff < step_depth_ff);
         default:             step_hit = 1'b0;
      endcase
   end

   // Decide the transaction and the next state
   always_comb begin
      step_mode_in    = step_mode_ff;
      step_depth_in   = step_depth_ff;
      step_line_in    = step_line_ff;
      stop_depth_in   = stop_depth_ff;
      stop_line_in    = stop_line_ff;
      paused_in       = paused_ff;
      pending_in      = pending_ff;
      rsp_stopped_in  = 1'b0;
      rsp_reason_in   = dsbu_pkg::REASON_STEP;
      rsp_rejected_in = 1'b0;

      unique case (s1_action_ff)
         dsbu_pkg::ACT_INSTR: begin
            if (paused_ff) begin
               rsp_rejected_in = 1'b1;
            end else if (eligible) begin
               priority if (pending_ff) begin
                  pending_in     = 1'b0;
                  rsp_stopped_in = 1'b1;
                  rsp_reason_in  = dsbu_pkg::REASON_PAUSE;
               end else if (step_hit) begin
                  rsp_stopped_in = 1'b1;
                  rsp_reason_in  = dsbu_pkg::REASON_STEP;
               end else if (bp_hit) begin
                  rsp_stopped_in = 1'b1;
                  rsp_reason_in  = dsbu_pkg::REASON_BP;
               end else begin
                  rsp_stopped_in = 1'b0;
               end
               if (rsp_stopped_in) begin
                  step_mode_in  = dsbu_pkg::MODE_NONE;
                  stop_line_in  = s1_line_ff;
                  stop_depth_in = s1_depth_ff;
                  paused_in     = 1'b1;
               end
            end
         end
         dsbu_pkg::ACT_CONTINUE: begin
            step_mode_in = dsbu_pkg::MODE_NONE;
            paused_in    = 1'b0;
         end
         dsbu_pkg::ACT_STEP_OVR, dsbu_pkg::ACT_STEP_IN, dsbu_pkg::ACT_STEP_OUT: begin
            unique case (s1_action_ff)
               dsbu_pkg::ACT_STEP_OVR: step_mode_in = dsbu_pkg::MODE_OVER;
               dsbu_pkg::ACT_STEP_IN:  step_mode_in = dsbu_pkg::MODE_INTO;
               default:                step_mode_in = dsbu_pkg::MODE_OUT;
            endcase
            step_depth_in = stop_depth_ff;
            step_line_in  = stop_line_ff;
            paused_in     = 1'b0;
         end
         dsbu_pkg::ACT_PAUSE: begin
            pending_in = 1'b1;
         end
         default: begin
            // breakpoint writes go to the table; unused codes do nothing
         end
      endcase
   end

   // Commit state as the transaction leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         step_mode_ff  <= dsbu_pkg::MODE_NONE;
         step_depth_ff <= '0;
         step_line_ff  <= '0;
         stop_depth_ff <= '0;
         stop_line_ff  <= '0;
         paused_ff     <= 1'b0;
         pending_ff    <= 1'b0;
      end else if (advance) begin
         step_mode_ff  <= step_mode_in;
         step_depth_ff <= step_depth_in;
         step_line_ff  <= step_line_in;
         stop_depth_ff <= stop_depth_in;
         stop_line_ff  <= stop_line_in;
         paused_ff     <= paused_in;
         pending_ff    <= pending_in;
      end
   end

   // Output register: load on advance, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_stopped_ff  <= rsp_stopped_in;
         rsp_reason_ff   <= rsp_stopped_in ? rsp_reason_in : dsbu_pkg::REASON_STEP;
         rsp_frame_ff    <= rsp_stopped_in ? s1_frame_ff : '0;
         rsp_file_ff     <= rsp_stopped_in ? s1_file_ff : '0;
         rsp_line_ff     <= rsp_stopped_in ? s1_line_ff : '0;
         rsp_paused_ff   <= paused_in;
         rsp_rejected_ff <= rsp_rejected_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.stopped     = rsp_stopped_ff;
   assign rsp_ch.stop_reason = rsp_reason_ff;
   assign rsp_ch.stop_frame  = rsp_frame_ff;
   assign rsp_ch.stop_file   = rsp_file_ff;
   assign rsp_ch.stop_line   = rsp_line_ff;
   assign rsp_ch.paused      = rsp_paused_ff;
   assign rsp_ch.rejected    = rsp_rejected_ff;

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for debug_step_breakpoint_unit: directed and random
// instruction events and host commands, checked against an in-bench stop predictor.
// Depends on dsbu_pkg, the three dsbu channel interfaces and the unit's RTL.
`timescale 1ns / 1ps

module tb_top;

   localparam int FB = dsbu_pkg::FILE_BITS_DEF;
   localparam int LB = dsbu_pkg::LINE_BITS_DEF;
   localparam int DB = dsbu_pkg::DEPTH_BITS_DEF;
   localparam int AB = dsbu_pkg::ACTION_BITS;
   localparam int RB = dsbu_pkg::REASON_BITS;
   localparam int WB = dsbu_pkg::FRAME_BITS;
   localparam int SB = dsbu_pkg::SLOT_BITS;
   localparam int NSLOT = dsbu_pkg::BP_SLOTS_DEF;
   localparam logic [AB-1:0] ACT_UNUSED = 3'd7;
   localparam int unsigned CYCLE_LIMIT = 200000;

   typedef struct {
      logic [AB-1:0] action;
      logic [FB-1:0] file_id;
      logic [LB-1:0] line;
      logic [DB-1:0] call_depth;
      logic [WB-1:0] frame_num;
      logic          has_line_info;
      logic [SB-1:0] slot;
      logic          slot_enable;
      int unsigned   gap;
   } dbg_event_type;

   typedef struct {
      logic          stopped;
      logic [RB-1:0] stop_reason;
      logic [WB-1:0] stop_frame;
      logic [FB-1:0] stop_file;
      logic [LB-1:0] stop_line;
      logic          paused;
      logic          rejected;
   } verdict_type;

   logic clock;
   logic reset;

   dsbu_req_if req_if ();
   dsbu_rsp_if rsp_if ();
   dsbu_csr_if csr_if ();

   debug_step_breakpoint_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // Predicted unit state
   logic [dsbu_pkg::MODE_BITS-1:0] step_mode_q;
   logic [DB-1:0]        start_depth;
   logic [LB-1:0]        start_line;
   logic [DB-1:0]        last_stop_depth;
   logic [LB-1:0]        last_stop_line;
   logic                 is_paused;
   logic                 pause_armed;
   logic                 hook_on;
   logic                 bp_armed [NSLOT];
   logic [FB-1:0]        bp_file  [NSLOT];
   logic [LB-1:0]        bp_line  [NSLOT];

   // Stimulus and scoreboard stores
   dbg_event_type event_q[$];
   verdict_type   verdict_q[$];
   logic          hook_write_q[$];

   int unsigned fail_count;
   int unsigned rsp_count;
   int unsigned cycle_count;
   int unsigned n_step_stops, n_pause_stops, n_bp_stops, n_rejects, n_ignored;
   int unsigned hook_writes;
   int unsigned walk_depth;

   // Driver and receiver state
   bit            offering;
   bit            have_next;
   int unsigned   gap_left;
   dbg_event_type cur_ev;
   dbg_event_type next_ev;
   int unsigned   stall_left;
   bit            csr_busy;
   logic          csr_val;

   // Work out the response the unit owes for one accepted transaction
   function automatic verdict_type decide_stop(input dbg_event_type ev);
      verdict_type v;
      bit          hit;
      v = '{default: '0};
      hit = 1'b0;
      case (ev.action)
         dsbu_pkg::ACT_INSTR: begin
            if (is_paused) begin
               v.rejected = 1'b1;
               n_rejects++;
            end else if (!hook_on || !ev.has_line_info ||
                         ev.frame_num >= ev.call_depth) begin
               n_ignored++;
            end else begin
               if (pause_armed) begin
                  pause_armed = 1'b0;
                  v.stopped = 1'b1;
                  v.stop_reason = dsbu_pkg::REASON_PAUSE;
               end else begin
                  v.stop_reason = dsbu_pkg::REASON_STEP;
                  case (step_mode_q)
                     dsbu_pkg::MODE_OVER: v.stopped = (ev.call_depth < start_depth) ||
                        (ev.call_depth == start_depth && ev.line != start_line);
                     dsbu_pkg::MODE_INTO: v.stopped = (ev.call_depth != start_depth) ||
                        (ev.line != start_line);
                     dsbu_pkg::MODE_OUT:  v.stopped = (ev.call_depth < start_depth);
                     default:             v.stopped = 1'b0;
                  endcase
               end
               // breakpoints only count when nothing higher already stopped
               if (!v.stopped) begin
                  for (int k = 0; k < NSLOT; k++)
                     if (bp_armed[k] && bp_file[k] == ev.file_id && bp_line[k] == ev.line)
                        hit = 1'b1;
                  if (hit) begin
                     v.stopped = 1'b1;
                     v.stop_reason = dsbu_pkg::REASON_BP;
                  end
               end
               if (v.stopped) begin
                  step_mode_q = dsbu_pkg::MODE_NONE;
                  last_stop_line = ev.line;
                  last_stop_depth = ev.call_depth;
                  is_paused = 1'b1;
                  v.stop_frame = ev.frame_num;
                  v.stop_file = ev.file_id;
                  v.stop_line = ev.line;
                  if (v.stop_reason == dsbu_pkg::REASON_PAUSE) n_pause_stops++;
                  else if (v.stop_reason == dsbu_pkg::REASON_BP) n_bp_stops++;
                  else n_step_stops++;
               end else begin
                  v.stop_reason = dsbu_pkg::REASON_STEP;
               end
            end
         end
         dsbu_pkg::ACT_CONTINUE: begin
            step_mode_q = dsbu_pkg::MODE_NONE;
            is_paused = 1'b0;
         end
         dsbu_pkg::ACT_STEP_OVR, dsbu_pkg::ACT_STEP_IN, dsbu_pkg::ACT_STEP_OUT: begin
            step_mode_q = (ev.action == dsbu_pkg::ACT_STEP_OVR) ? dsbu_pkg::MODE_OVER :
                          (ev.action == dsbu_pkg::ACT_STEP_IN)  ? dsbu_pkg::MODE_INTO :
                                                                  dsbu_pkg::MODE_OUT;
            start_depth = last_stop_depth;
            start_line = last_stop_line;
            is_paused = 1'b0;
         end
         dsbu_pkg::ACT_PAUSE: pause_armed = 1'b1;
         dsbu_pkg::ACT_BP_WRITE: begin
            if (ev.slot < NSLOT) begin
               bp_armed[ev.slot] = ev.slot_enable;
               bp_file[ev.slot] = ev.slot_enable ? ev.file_id : '0;
               bp_line[ev.slot] = ev.slot_enable ? ev.line : '0;
            end
         end
         default: ;
      endcase
      v.paused = is_paused;
      return v;
   endfunction

   function automatic dbg_event_type make_event(input logic [AB-1:0] act,
                                                input logic [FB-1:0] file,
                                                input logic [LB-1:0] ln,
                                                input logic [DB-1:0] depth,
                                                input logic [WB-1:0] frame,
                                                input logic has_line,
                                                input logic [SB-1:0] slot,
                                                input logic en);
      dbg_event_type ev;
      ev.action = act;
      ev.file_id = file;
      ev.line = ln;
      ev.call_depth = depth;
      ev.frame_num = frame;
      ev.has_line_info = has_line;
      ev.slot = slot;
      ev.slot_enable = en;
      ev.gap = $urandom_range(0, 4);
      return ev;
   endfunction

   // Append one transaction to the stimulus queue
   function automatic void add_event(input dbg_event_type ev);
      event_q.insert(event_q.size(), ev);
   endfunction

   // Mostly plausible program flow on a few files and lines, with some raw noise
   function automatic dbg_event_type random_event(input bit burst);
      dbg_event_type ev;
      int unsigned   pick;
      ev.action = dsbu_pkg::ACT_INSTR;
      ev.file_id = FB'($urandom);
      ev.line = LB'($urandom);
      ev.call_depth = DB'($urandom);
      ev.frame_num = WB'($urandom);
      ev.has_line_info = 1'($urandom);
      ev.slot = SB'($urandom);
      ev.slot_enable = 1'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
         case ($urandom_range(0, 19))
            0, 1, 2: if (walk_depth > 0) walk_depth--;
            3, 4, 5: if (walk_depth < 255) walk_depth++;
            6:       walk_depth = 0;
            7:       walk_depth = 255;
            8:       walk_depth = $urandom_range(1, 6);
            default: ;
         endcase
         if ($urandom_range(0, 9) != 0) begin
            ev.file_id = FB'($urandom_range(0, 3));
            ev.line = LB'($urandom_range(0, 7));
            ev.call_depth = DB'(walk_depth);
            ev.frame_num = (walk_depth == 0) ? '0 :
                           WB'($urandom_range(0, walk_depth - 1));
            ev.has_line_info = ($urandom_range(0, 15) != 0);
         end
      end else if (pick < 66) ev.action = dsbu_pkg::ACT_CONTINUE;
      else if (pick < 71) ev.action = dsbu_pkg::ACT_STEP_OVR;
      else if (pick < 76) ev.action = dsbu_pkg::ACT_STEP_IN;
      else if (pick < 80) ev.action = dsbu_pkg::ACT_STEP_OUT;
      else if (pick < 85) ev.action = dsbu_pkg::ACT_PAUSE;
      else if (pick < 98) begin
         ev.action = dsbu_pkg::ACT_BP_WRITE;
         ev.slot_enable = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) < 7) begin
            ev.file_id = FB'($urandom_range(0, 3));
            ev.line = LB'($urandom_range(0, 7));
         end
      end else ev.action = ACT_UNUSED;
      ev.gap = burst ? 0 : $urandom_range(0, 4);
      return ev;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // Hold until every queued transaction has gone and every response has come back
   task automatic wait_drained();
      while (event_q.size() > 0 || have_next || offering || verdict_q.size() > 0 ||
             hook_write_q.size() > 0 || csr_busy)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_hook(input logic value);
      hook_write_q.insert(hook_write_q.size(), value);
      wait_drained();
   endtask

   // Clock and reset
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.action = dsbu_pkg::ACT_INSTR;
      req_if.file_id = '0;
      req_if.line = '0;
      req_if.call_depth = '0;
      req_if.frame_num = '0;
      req_if.has_line_info = 1'b0;
      req_if.slot = '0;
      req_if.slot_enable = 1'b0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.hook_enabled = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // Reset values of the predicted state
   initial begin
      step_mode_q = dsbu_pkg::MODE_NONE;
      start_depth = '0;
      start_line = '0;
      last_stop_depth = '0;
      last_stop_line = '0;
      is_paused = 1'b0;
      pause_armed = 1'b0;
      hook_on = 1'b0;
      for (int k = 0; k < NSLOT; k++) begin
         bp_armed[k] = 1'b0;
         bp_file[k] = '0;
         bp_line[k] = '0;
      end
   end

   // Request driver: present one transaction at a time, honouring its gap
   always @(posedge clock) begin
      if (reset) begin
         offering = 1'b0;
         have_next = 1'b0;
         gap_left = 0;
         req_if.valid <= 1'b0;
      end else begin
         if (offering && req_if.ready) begin
            verdict_q.insert(verdict_q.size(), decide_stop(cur_ev));
            offering = 1'b0;
         end
         if (!offering) begin
            if (!have_next && event_q.size() > 0) begin
               next_ev = event_q.pop_front();
               have_next = 1'b1;
               gap_left = next_ev.gap;
            end
            if (have_next) begin
               if (gap_left == 0) begin
                  cur_ev = next_ev;
                  have_next = 1'b0;
                  offering = 1'b1;
               end else begin
                  gap_left--;
               end
            end
         end
         req_if.valid <= offering;
         req_if.action <= cur_ev.action;
         req_if.file_id <= cur_ev.file_id;
         req_if.line <= cur_ev.line;
         req_if.call_depth <= cur_ev.call_depth;
         req_if.frame_num <= cur_ev.frame_num;
         req_if.has_line_info <= cur_ev.has_line_info;
         req_if.slot <= cur_ev.slot;
         req_if.slot_enable <= cur_ev.slot_enable;
      end
   end

   // Hook enable writes
   always @(posedge clock) begin
      if (reset) begin
         csr_busy = 1'b0;
         csr_val = 1'b0;
         csr_if.valid <= 1'b0;
      end else begin
         if (csr_busy && csr_if.ready) begin
            hook_on = csr_val;
            hook_writes++;
            csr_busy = 1'b0;
         end
         if (!csr_busy && hook_write_q.size() > 0) begin
            csr_val = hook_write_q.pop_front();
            csr_busy = 1'b1;
         end
         csr_if.valid <= csr_busy;
         csr_if.hook_enabled <= csr_val;
      end
   end

   // Response monitor: check each transaction, then draw the next stall
   always @(posedge clock) begin : rsp_monitor
      verdict_type want;
      if (reset) begin
         stall_left = 0;
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (verdict_q.size() == 0) begin
               fail_count++;
               $display("%0t: response with nothing expected, actual stopped=%0b paused=%0b",
                        $time, rsp_if.stopped, rsp_if.paused);
            end else begin
               want = verdict_q.pop_front();
               check_field("stopped", 32'(want.stopped), 32'(rsp_if.stopped));
               check_field("stop_reason", 32'(want.stop_reason), 32'(rsp_if.stop_reason));
               check_field("stop_frame", 32'(want.stop_frame), 32'(rsp_if.stop_frame));
               check_field("stop_file", 32'(want.stop_file), 32'(rsp_if.stop_file));
               check_field("stop_line", 32'(want.stop_line), 32'(rsp_if.stop_line));
               check_field("paused", 32'(want.paused), 32'(rsp_if.paused));
               check_field("rejected", 32'(want.rejected), 32'(rsp_if.rejected));
            end
            rsp_count++;
            // long hold-off now and then so the unit backs up into the request side
            if (rsp_count % 300 == 150) stall_left = 120;
            else if ((rsp_count / 64) % 3 == 2) stall_left = 0;
            else stall_left = $urandom_range(0, 4);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_if.ready <= (stall_left == 0);
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d responses still expected", $time, verdict_q.size());
         $display("debug_step_breakpoint_unit verification failed");
         $finish;
      end
   end

   // Stimulus phases
   initial begin : stimulus
      int unsigned phase_len [5];
      logic        phase_hook [5];
      phase_len = '{200, 200, 100, 150, 150};
      phase_hook = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
      walk_depth = 3;

      // Hook still off after reset: events pass over, a pause request stays pending
      add_event(make_event(dsbu_pkg::ACT_INSTR, 8'd1, 20'd1, 8'd2, 8'd0, 1'b1,
                           4'd0, 1'b0));
      add_event(make_event(dsbu_pkg::ACT_PAUSE, '0, '0, '0, '0, 1'b0, 4'd0, 1'b0));
      add_event(make_event(dsbu_pkg::ACT_INSTR, 8'd1, 20'd2, 8'd2, 8'd1, 1'b1,
                           4'd0, 1'b0));
      wait_drained();
      write_hook(1'b1);

      // No line info, frame not below depth, then the pending pause fires
      add_event(make_event(dsbu_pkg::ACT_INSTR, 8'd2, 20'd3, 8'd4, 8'd0, 1'b0,
                           4'd0, 1'b0));
      add_event(make_event(dsbu_pkg::ACT_INSTR, 8'd2, 20'd3, 8'd4, 8'd4, 1'b1,
                           4'd0, 1'b0));
      add_event(make_event(dsbu_pkg::ACT_INSTR, 8'd0, 20'd0, 8'd0, 8'd0, 1'b1,
                           4'd0, 1'b0));
      add_event(make_event(dsbu_pkg::ACT_INSTR, 8'hFF, 20'hFFFFF, 8'hFF, 8'hFE, 1'b1,
                           4'd0, 1'b0));
      // Rejected while paused
      add_event(make_event(dsbu_pkg::ACT_INSTR, 8'h5, 20'h5, 8'd3, 8'd1, 1'b1,
                           4'd0, 1'b0));
      add_event(make_event(dsbu_pkg::ACT_CONTINUE, '0, '0, '0, '0, 1'b0, 4'd0, 1'b0));
      // Arm the lowest and highest slots, then hit the top one
      add_event(make_event(dsbu_pkg::ACT_BP_WRITE, 8'd0, 20'd0, '0, '0, 1'b0,
                           4'd0, 1'b1));
      add_event(make_event(dsbu_pkg::ACT_BP_WRITE, 8'hFF, 20'hFFFFF, '0, '0, 1'b0,
                           4'hF, 1'b1));
      add_event(make_event(dsbu_pkg::ACT_INSTR, 8'hFF, 20'hFFFFF, 8'd1, 8'd0, 1'b1,
                           4'd0, 1'b0));
      // Step over: same line holds, deeper call holds, new line stops
      add_event(make_event(dsbu_pkg::ACT_STEP_OVR, '0, '0, '0, '0, 1'b0, 4'd0, 1'b0));
      add_event(make_event(dsbu_pkg::ACT_INSTR, 8'd3, 20'hFFFFF, 8'd1, 8'd0, 1'b1,
                           4'd0, 1'b0));
      add_event(make_event(dsbu_pkg::ACT_INSTR, 8'd3, 20'd5, 8'd2, 8'd1, 1'b1,
                           4'd0, 1'b0));
      add_event(make_event(dsbu_pkg::ACT_INSTR, 8'd3, 20'd6, 8'd1, 8'd0, 1'b1,
                           4'd0, 1'b0));
      // Step into stops on a deeper call
      add_event(make_event(dsbu_pkg::ACT_STEP_IN, '0, '0, '0, '0, 1'b0, 4'd0, 1'b0));
      add_event(make_event(dsbu_pkg::ACT_INSTR, 8'd3, 20'd6, 8'd2, 8'd1, 1'b1,
                           4'd0, 1'b0));
      // Step out holds at the same depth and stops on return
      add_event(make_event(dsbu_pkg::ACT_STEP_OUT, '0, '0, '0, '0, 1'b0, 4'd0, 1'b0));
      add_event(make_event(dsbu_pkg::ACT_INSTR, 8'd3, 20'd7, 8'd2, 8'd1, 1'b1,
                           4'd0, 1'b0));
      add_event(make_event(dsbu_pkg::ACT_INSTR, 8'd3, 20'd8, 8'd1, 8'd0, 1'b1,
                           4'd0, 1'b0));
      // Clear a slot, unused code, then commands while running
      add_event(make_event(dsbu_pkg::ACT_BP_WRITE, 8'hAA, 20'h55555, '0, '0, 1'b0,
                           4'hF, 1'b0));
      add_event(make_event(ACT_UNUSED, 8'hFF, 20'hFFFFF, 8'hFF, 8'hFF, 1'b1,
                           4'hF, 1'b1));
      add_event(make_event(dsbu_pkg::ACT_CONTINUE, '0, '0, '0, '0, 1'b0, 4'd0, 1'b0));
      add_event(make_event(dsbu_pkg::ACT_STEP_IN, '0, '0, '0, '0, 1'b0, 4'd0, 1'b0));
      // A pending pause survives continue
      add_event(make_event(dsbu_pkg::ACT_PAUSE, '0, '0, '0, '0, 1'b0, 4'd0, 1'b0));
      add_event(make_event(dsbu_pkg::ACT_CONTINUE, '0, '0, '0, '0, 1'b0, 4'd0, 1'b0));
      add_event(make_event(dsbu_pkg::ACT_INSTR, 8'd9, 20'd9, 8'd8, 8'd7, 1'b1,
                           4'd0, 1'b0));
      add_event(make_event(dsbu_pkg::ACT_CONTINUE, '0, '0, '0, '0, 1'b0, 4'd0, 1'b0));
      wait_drained();

      // Random phases, the fourth without any sender gaps
      for (int p = 0; p < 5; p++) begin
         write_hook(phase_hook[p]);
         for (int unsigned i = 0; i < phase_len[p]; i++)
            add_event(random_event(p == 3));
         wait_drained();
      end

      repeat (10) @(posedge clock);
      $display("Covered %0d responses over %0d hook writes; stops: %0d step, %0d pause, %0d bp.",
               rsp_count, hook_writes, n_step_stops, n_pause_stops, n_bp_stops);
      $display("Rejected while paused: %0d; instruction events passed over: %0d.",
               n_rejects, n_ignored);
      if (fail_count == 0) begin
         $display("debug_step_breakpoint_unit verification clean");
      end else begin
         $display("%0d field mismatches or stray responses", fail_count);
         $display("debug_step_breakpoint_unit verification failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/dsbu_pkg.sv
hdl/dsbu_req_if.sv
hdl/dsbu_rsp_if.sv
hdl/dsbu_csr_if.sv
hdl/dsbu_bp_table.sv
hdl/debug_step_breakpoint_unit.sv
verif/tb_top.sv
